// File: src/mfde_pkg.sv
// Shared types and constants of the monochrome framebuffer draw engine.
package mfde_pkg;

   localparam int COORD_W     = 14;   // internal signed coordinate width
   localparam int FRAME_BYTES = 1024; // bytes in the frame store
   localparam int ADDR_W      = 10;   // frame store address width
   localparam int IDX_W       = 18;   // width of an unclipped byte index

   typedef logic signed [COORD_W-1:0] coord_type;

   // Command kinds.
   localparam logic [2:0] KIND_PIXEL   = 3'd0;
   localparam logic [2:0] KIND_READ    = 3'd1;
   localparam logic [2:0] KIND_LINE    = 3'd2;
   localparam logic [2:0] KIND_OUTLINE = 3'd3;
   localparam logic [2:0] KIND_FILL    = 3'd4;
   localparam logic [2:0] KIND_CIRCLE  = 3'd5;
   localparam logic [2:0] KIND_DISC    = 3'd6;
   localparam logic [2:0] KIND_INVERT  = 3'd7;

   // Pixel operations.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_TOGGLE = 2'd2;

endpackage

// File: src/mono_framebuffer_draw_engine_top.sv
// Top level of the monochrome framebuffer draw engine.
//
//   channel   ports                      beat taken when
//   --------  -------------------------  ----------------------------
//   request   start, busy, req_*         start high while busy is low
//   response  rsp_valid, rsp_*           rsp_valid high (one cycle)
//
// After reset the engine sweeps the 1024-byte frame store to zero, one byte
// per cycle, and busy stays high until the sweep is done.
// Every command is handled alone. A plotted pixel costs a read and a write of
// the single-port frame store, in states S_PLOT_A and S_PLOT_B, after the
// rasterizer has stepped to it. A pixel position off the screen skips the
// write; span pixels off the screen are clipped away before the walk and are
// never visited. The receiver cannot stall the response beat, and a new
// command may start on the cycle the response beat is shown.
module mono_framebuffer_draw_engine_top
   import mfde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [11:0] req_x,
   input  logic signed [11:0] req_y,
   input  logic signed [11:0] req_x_end,
   input  logic signed [11:0] req_y_end,
   input  logic [10:0]        req_width,
   input  logic [10:0]        req_height,
   input  logic [10:0]        req_radius,
   input  logic               req_set_bit,
   output logic               rsp_valid,
   output logic               rsp_pixel_value,
   output logic [2:0]         rsp_done_kind
);

   localparam int ROW_BYTES = SCREEN_WIDTH / 8;

   localparam coord_type SCR_W = coord_type'(SCREEN_WIDTH);
   localparam coord_type SCR_H = coord_type'(SCREEN_HEIGHT);
   localparam coord_type ONE   = coord_type'(1);

   // Sequencer states.
   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_PLOT_A  = 5'd2;
   localparam logic [4:0] S_PLOT_B  = 5'd3;
   localparam logic [4:0] S_RD_A    = 5'd4;
   localparam logic [4:0] S_RD_B    = 5'd5;
   localparam logic [4:0] S_LN      = 5'd6;
   localparam logic [4:0] S_LN_NX   = 5'd7;
   localparam logic [4:0] S_R_ROW   = 5'd8;
   localparam logic [4:0] S_R_SIDE  = 5'd9;
   localparam logic [4:0] S_R_NROW  = 5'd10;
   localparam logic [4:0] S_SP      = 5'd11;
   localparam logic [4:0] S_SP_COL  = 5'd12;
   localparam logic [4:0] S_SP_NX   = 5'd13;
   localparam logic [4:0] S_FC_INIT = 5'd14;
   localparam logic [4:0] S_FC_SHR  = 5'd15;
   localparam logic [4:0] S_FC_AFT  = 5'd16;
   localparam logic [4:0] S_CI_LOOP = 5'd17;
   localparam logic [4:0] S_CI_PT   = 5'd18;
   localparam logic [4:0] S_CI_PTNX = 5'd19;
   localparam logic [4:0] S_CI_UPD  = 5'd20;
   localparam logic [4:0] S_DONE    = 5'd21;

   logic [4:0]  state_ff;
   logic [4:0]  ret_ff;       // state to resume after a plot
   logic [4:0]  span_ret_ff;  // state to resume after a span
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic [2:0]  kind_ff;
   logic [1:0]  op_ff;
   logic        pv_ff;
   logic        rsp_valid_ff;

   // Pixel being plotted.
   coord_type   px_ff, py_ff;

   // Line and circle state.
   coord_type   cx_ff, cy_ff, ex_ff, ey_ff;
   logic [11:0] dx_ff, dy_ff;
   logic        sx_ff, sy_ff;
   logic signed [15:0] err_ff;
   logic [10:0] ca_ff, cb_ff, rad_ff;
   logic signed [19:0] cd_ff;
   logic [2:0]  oct_ff;

   // Rectangle and span state.
   coord_type   xl_ff, xr_ff, yt_ff, yb_ff, row_ff, col_ff;

   // Filled circle state.
   logic [10:0] xm_ff, fay_ff;
   logic [21:0] xm2_ff, ay2_ff, rr_ff;
   logic        half_ff;

   // Frame store.
   logic [7:0]        mem [0:FRAME_BYTES-1];
   logic [7:0]        rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;

   // Clipping and address of the current pixel.
   logic [IDX_W-1:0] idx;
   logic             pix_ok;
   logic [7:0]       mask;

   always_comb begin
      idx = IDX_W'(py_ff[9:0]) * IDX_W'(ROW_BYTES) + IDX_W'(px_ff[12:3]);
      pix_ok = (px_ff >= 0) && (px_ff < SCR_W) && (py_ff >= 0) && (py_ff < SCR_H)
               && (idx < IDX_W'(FRAME_BYTES));
      mask = 8'h80 >> px_ff[2:0];
   end

   // Span bounds clipped to the screen.
   coord_type span_cs, span_ce;
   logic      row_ok;

   always_comb begin
      span_cs = (xl_ff < 0) ? '0 : xl_ff;
      span_ce = (xr_ff > SCR_W - ONE) ? SCR_W - ONE : xr_ff;
      row_ok  = (row_ff >= 0) && (row_ff < SCR_H);
   end

   // Bresenham step terms.
   logic signed [16:0] e2;
   logic               step_x, step_y;
   logic signed [15:0] err_next;

   always_comb begin
      e2       = {err_ff, 1'b0};
      step_x   = e2 > -$signed({5'd0, dy_ff});
      step_y   = e2 < $signed({5'd0, dx_ff});
      err_next = err_ff - (step_x ? $signed({4'd0, dy_ff}) : 16'sd0)
                        + (step_y ? $signed({4'd0, dx_ff}) : 16'sd0);
   end

   // Circle octant point.
   coord_type ca_c, cb_c, oct_x, oct_y;

   always_comb begin
      ca_c = coord_type'({1'b0, ca_ff});
      cb_c = coord_type'({1'b0, cb_ff});
      case (oct_ff)
         3'd0: begin oct_x = cx_ff + ca_c; oct_y = cy_ff + cb_c; end
         3'd1: begin oct_x = cx_ff - ca_c; oct_y = cy_ff + cb_c; end
         3'd2: begin oct_x = cx_ff + ca_c; oct_y = cy_ff - cb_c; end
         3'd3: begin oct_x = cx_ff - ca_c; oct_y = cy_ff - cb_c; end
         3'd4: begin oct_x = cx_ff + cb_c; oct_y = cy_ff + ca_c; end
         3'd5: begin oct_x = cx_ff - cb_c; oct_y = cy_ff + ca_c; end
         3'd6: begin oct_x = cx_ff + cb_c; oct_y = cy_ff - ca_c; end
         default: begin oct_x = cx_ff - cb_c; oct_y = cy_ff - ca_c; end
      endcase
   end

   // Request fields widened to the internal coordinate width.
   coord_type rx, ry, rxe, rye, rw, rh;
   logic signed [12:0] ddx, ddy;

   always_comb begin
      rx  = {{2{req_x[11]}}, req_x};
      ry  = {{2{req_y[11]}}, req_y};
      rxe = {{2{req_x_end[11]}}, req_x_end};
      rye = {{2{req_y_end[11]}}, req_y_end};
      rw  = coord_type'({1'b0, req_width});
      rh  = coord_type'({1'b0, req_height});
      ddx = {req_x_end[11], req_x_end} - {req_x[11], req_x};
      ddy = {req_y_end[11], req_y_end} - {req_y[11], req_y};
   end

   // Frame store port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = idx[ADDR_W-1:0];
      mem_wdata = rd_ff | mask;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = '0;
         end
         S_PLOT_B: begin
            mem_we = 1'b1;
            case (op_ff)
               OP_SET:    mem_wdata = rd_ff | mask;
               OP_TOGGLE: mem_wdata = rd_ff ^ mask;
               default:   mem_wdata = rd_ff & ~mask;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   // Command sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         ret_ff       <= S_DONE;
         span_ret_ff  <= S_DONE;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_W'(FRAME_BYTES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_kind;
                  op_ff   <= req_set_bit ? OP_SET : OP_CLEAR;
                  pv_ff   <= 1'b0;
                  px_ff   <= rx;
                  py_ff   <= ry;
                  cx_ff   <= rx;
                  cy_ff   <= ry;
                  ex_ff   <= rxe;
                  ey_ff   <= rye;
                  dx_ff   <= ddx[12] ? 12'(-ddx) : ddx[11:0];
                  dy_ff   <= ddy[12] ? 12'(-ddy) : ddy[11:0];
                  sx_ff   <= rx < rxe;
                  sy_ff   <= ry < rye;
                  err_ff  <= 16'($signed(ddx[12] ? -ddx : ddx))
                             - 16'($signed(ddy[12] ? -ddy : ddy));
                  xl_ff   <= rx;
                  xr_ff   <= rx + rw - ONE;
                  yt_ff   <= ry;
                  yb_ff   <= ry + rh - ONE;
                  row_ff  <= (ry < 0) ? '0 : ry;
                  rad_ff  <= req_radius;
                  ca_ff   <= '0;
                  cb_ff   <= req_radius;
                  cd_ff   <= 20'sd3 - $signed({8'd0, req_radius, 1'b0});
                  ret_ff  <= S_DONE;
                  case (req_kind)
                     KIND_PIXEL:  state_ff <= S_PLOT_A;
                     KIND_READ:   state_ff <= S_RD_A;
                     KIND_LINE:   state_ff <= S_LN;
                     KIND_CIRCLE: state_ff <= S_CI_LOOP;
                     KIND_DISC:   state_ff <= S_FC_INIT;
                     default: begin
                        if (req_kind == KIND_INVERT) begin
                           op_ff <= OP_TOGGLE;
                        end
                        if (req_width == '0 || req_height == '0) begin
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_R_ROW;
                        end
                     end
                  endcase
               end
            end
            S_PLOT_A: begin
               state_ff <= pix_ok ? S_PLOT_B : ret_ff;
            end
            S_PLOT_B: begin
               state_ff <= ret_ff;
            end
            S_RD_A: begin
               state_ff <= pix_ok ? S_RD_B : S_DONE;
            end
            S_RD_B: begin
               pv_ff    <= rd_ff[3'd7 - px_ff[2:0]];
               state_ff <= S_DONE;
            end
            S_LN: begin
               px_ff    <= cx_ff;
               py_ff    <= cy_ff;
               ret_ff   <= S_LN_NX;
               state_ff <= S_PLOT_A;
            end
            S_LN_NX: begin
               if (cx_ff == ex_ff && cy_ff == ey_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  err_ff <= err_next;
                  if (step_x) cx_ff <= sx_ff ? cx_ff + ONE : cx_ff - ONE;
                  if (step_y) cy_ff <= sy_ff ? cy_ff + ONE : cy_ff - ONE;
                  state_ff <= S_LN;
               end
            end
            S_R_ROW: begin
               if (row_ff > yb_ff || row_ff >= SCR_H) begin
                  state_ff <= S_DONE;
               end else if (kind_ff != KIND_OUTLINE || row_ff == yt_ff
                            || row_ff == yb_ff) begin
                  span_ret_ff <= S_R_NROW;
                  state_ff    <= S_SP;
               end else begin
                  px_ff    <= xl_ff;
                  py_ff    <= row_ff;
                  ret_ff   <= S_R_SIDE;
                  state_ff <= S_PLOT_A;
               end
            end
            S_R_SIDE: begin
               px_ff    <= xr_ff;
               py_ff    <= row_ff;
               ret_ff   <= S_R_NROW;
               state_ff <= S_PLOT_A;
            end
            S_R_NROW: begin
               row_ff   <= row_ff + ONE;
               state_ff <= S_R_ROW;
            end
            S_SP: begin
               if (!row_ok || span_cs > span_ce) begin
                  state_ff <= span_ret_ff;
               end else begin
                  col_ff   <= span_cs;
                  state_ff <= S_SP_COL;
               end
            end
            S_SP_COL: begin
               px_ff    <= col_ff;
               py_ff    <= row_ff;
               ret_ff   <= S_SP_NX;
               state_ff <= S_PLOT_A;
            end
            S_SP_NX: begin
               if (col_ff >= span_ce) begin
                  state_ff <= span_ret_ff;
               end else begin
                  col_ff   <= col_ff + ONE;
                  state_ff <= S_SP_COL;
               end
            end
            S_FC_INIT: begin
               rr_ff    <= rad_ff * rad_ff;
               xm2_ff   <= rad_ff * rad_ff;
               xm_ff    <= rad_ff;
               fay_ff   <= '0;
               ay2_ff   <= '0;
               state_ff <= S_FC_SHR;
            end
            S_FC_SHR: begin
               if (xm_ff != '0 && ({1'b0, xm2_ff} + {1'b0, ay2_ff}) > {1'b0, rr_ff}) begin
                  xm2_ff <= xm2_ff - 22'({xm_ff, 1'b0} - 12'd1);
                  xm_ff  <= xm_ff - 1'b1;
               end else begin
                  row_ff      <= cy_ff + coord_type'({1'b0, fay_ff});
                  xl_ff       <= cx_ff - coord_type'({1'b0, xm_ff});
                  xr_ff       <= cx_ff + coord_type'({1'b0, xm_ff});
                  half_ff     <= 1'b0;
                  span_ret_ff <= S_FC_AFT;
                  state_ff    <= S_SP;
               end
            end
            S_FC_AFT: begin
               if (!half_ff && fay_ff != '0) begin
                  half_ff  <= 1'b1;
                  row_ff   <= cy_ff - coord_type'({1'b0, fay_ff});
                  state_ff <= S_SP;
               end else if (fay_ff == rad_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  ay2_ff   <= ay2_ff + 22'({fay_ff, 1'b0} + 12'd1);
                  fay_ff   <= fay_ff + 1'b1;
                  state_ff <= S_FC_SHR;
               end
            end
            S_CI_LOOP: begin
               if (ca_ff > cb_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  oct_ff   <= '0;
                  state_ff <= S_CI_PT;
               end
            end
            S_CI_PT: begin
               px_ff    <= oct_x;
               py_ff    <= oct_y;
               ret_ff   <= S_CI_PTNX;
               state_ff <= S_PLOT_A;
            end
            S_CI_PTNX: begin
               oct_ff   <= oct_ff + 1'b1;
               state_ff <= (oct_ff == 3'd7) ? S_CI_UPD : S_CI_PT;
            end
            S_CI_UPD: begin
               if (cd_ff <= 0) begin
                  cd_ff <= cd_ff + $signed({7'd0, ca_ff, 2'b00}) + 20'sd6;
               end else begin
                  cd_ff <= cd_ff + $signed({7'd0, ca_ff, 2'b00})
                                 - $signed({7'd0, cb_ff, 2'b00}) + 20'sd10;
                  cb_ff <= cb_ff - 1'b1;
               end
               ca_ff    <= ca_ff + 1'b1;
               // Stepping b below zero ends the walk; this happens only for a
               // zero radius, where b cannot hold the negative value.
               state_ff <= (cd_ff > 0 && cb_ff == '0) ? S_DONE : S_CI_LOOP;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = pv_ff;
   assign rsp_done_kind   = kind_ff;

endmodule
